>>> hdl/iwfr_pkg.sv
// ----------------------------------------------------------------------------
// iwfr_pkg
// shared types, constants and helpers for the world-frame inertia rotation
// ----------------------------------------------------------------------------
package iwfr_pkg;

    localparam int QUAT_FRAC = 30;
    localparam int TERM_W    = 35;
    localparam int ACC_W     = 37;
    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] ROW_NONE = 2'd3;
    localparam logic [3:0] QTERM_LAST = 4'd8;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] body_row_x;
        logic signed [31:0] body_row_y;
        logic signed [31:0] body_row_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               overflow;
        logic               last_row;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_QUAT,
        PH_AMAT,
        PH_WMAT
    } phase_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       acc_en;
        logic       rot_en;
        phase_t     phase;
        logic [3:0] qidx;
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] k;
        logic [1:0] orow;
    } dp_cmd_t;

    // quaternion component pair per rotation term:
    // xx yy zz xy xz yz xw yw zw, components x=0 y=1 z=2 w=3
    function automatic logic [3:0] quat_pair(input logic [3:0] idx);
        logic [3:0] p;
        case (idx)
            4'd0:    p = {2'd0, 2'd0};
            4'd1:    p = {2'd1, 2'd1};
            4'd2:    p = {2'd2, 2'd2};
            4'd3:    p = {2'd0, 2'd1};
            4'd4:    p = {2'd0, 2'd2};
            4'd5:    p = {2'd1, 2'd2};
            4'd6:    p = {2'd0, 2'd3};
            4'd7:    p = {2'd1, 2'd3};
            4'd8:    p = {2'd2, 2'd3};
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    // saturate to signed 32 bits, msb of result is the overflow flag
    function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [32:0] res;
        if (v > $signed(ACC_W'(32'sh7fffffff))) begin
            res = {1'b1, 32'h7fffffff};
        end else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h80000000})) begin
            res = {1'b1, 32'h80000000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

>>> hdl/iwfr_ctrl.sv
// ----------------------------------------------------------------------------
// iwfr_ctrl
// sequencer for load, rotation terms, R*I, (R*I)*R^T and row output
// ----------------------------------------------------------------------------
module iwfr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      s_row_index,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output iwfr_pkg::dp_cmd_t cmd
);
    import iwfr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_QMUL, ST_QACC, ST_ROT,
        ST_AMUL, ST_AACC, ST_WMUL, ST_WACC, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [3:0] q_reg;
    logic [1:0] r_reg, c_reg, k_reg, orow_reg;
    logic       mac_last;

    assign mac_last = (r_reg == ROW_LAST) && (c_reg == ROW_LAST) && (k_reg == ROW_LAST);
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);

    always_comb begin
        cmd        = '0;
        cmd.load   = s_ready && s_valid && (s_row_index != ROW_NONE);
        cmd.mul_en = (state_reg == ST_QMUL) || (state_reg == ST_AMUL) ||
                     (state_reg == ST_WMUL);
        cmd.acc_en = (state_reg == ST_QACC) || (state_reg == ST_AACC) ||
                     (state_reg == ST_WACC);
        cmd.rot_en = (state_reg == ST_ROT);
        case (state_reg)
            ST_QMUL, ST_QACC: cmd.phase = PH_QUAT;
            ST_WMUL, ST_WACC: cmd.phase = PH_WMAT;
            default:          cmd.phase = PH_AMAT;
        endcase
        cmd.qidx = q_reg;
        cmd.r    = r_reg;
        cmd.c    = c_reg;
        cmd.k    = k_reg;
        cmd.orow = orow_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            q_reg     <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
            orow_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_row_index == ROW_LAST) begin
                        state_reg <= ST_QMUL;
                        q_reg     <= '0;
                    end
                end
                ST_QMUL: state_reg <= ST_QACC;
                ST_QACC: begin
                    if (q_reg == QTERM_LAST) begin
                        state_reg <= ST_ROT;
                    end else begin
                        q_reg     <= q_reg + 4'd1;
                        state_reg <= ST_QMUL;
                    end
                end
                ST_ROT: begin
                    state_reg <= ST_AMUL;
                    r_reg <= '0;
                    c_reg <= '0;
                    k_reg <= '0;
                end
                ST_AMUL, ST_WMUL: begin
                    state_reg <= (state_reg == ST_AMUL) ? ST_AACC : ST_WACC;
                end
                ST_AACC, ST_WACC: begin
                    // walk k fastest, then column, then row
                    if (k_reg != ROW_LAST) begin
                        k_reg <= k_reg + 2'd1;
                    end else begin
                        k_reg <= '0;
                        if (c_reg != ROW_LAST) begin
                            c_reg <= c_reg + 2'd1;
                        end else begin
                            c_reg <= '0;
                            r_reg <= (r_reg == ROW_LAST) ? 2'd0 : r_reg + 2'd1;
                        end
                    end
                    if (mac_last) begin
                        state_reg <= (state_reg == ST_AACC) ? ST_WMUL : ST_OUT;
                        orow_reg  <= '0;
                    end else begin
                        state_reg <= (state_reg == ST_AACC) ? ST_AMUL : ST_WMUL;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (orow_reg == ROW_LAST) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            orow_reg <= orow_reg + 2'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/iwfr_datapath.sv
// ----------------------------------------------------------------------------
// iwfr_datapath
// operand storage, shared 32x32 multiplier, rounding accumulator, saturation
// ----------------------------------------------------------------------------
module iwfr_datapath (
    input  logic                aclk,
    input  iwfr_pkg::dp_cmd_t   cmd,
    input  iwfr_pkg::in_item_t  s_data,
    output iwfr_pkg::out_item_t m_data
);
    import iwfr_pkg::*;

    logic signed [31:0]       imat_reg [9];
    logic signed [31:0]       quat_reg [4];
    logic signed [TERM_W-1:0] term_reg [9];
    logic signed [31:0]       rot_reg  [9];
    logic signed [31:0]       amat_reg [9];
    logic signed [31:0]       wmat_reg [9];
    logic [2:0]               ov_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [63:0]       prod_reg;

    logic signed [31:0]       op_a, op_b;
    logic [3:0]               pair;
    logic signed [64:0]       rsum;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  acc_next;
    logic [32:0]              acc_sat;
    logic [3:0]               rk, kc, rc, ck;
    logic signed [ACC_W-1:0]  rot_raw [9];
    logic [32:0]              rot_sat [9];
    logic signed [ACC_W-1:0]  xx, yy, zz, xy, xz, yz, xw, yw, zw, one;
    logic [3:0]               obase;

    assign pair = quat_pair(cmd.qidx);
    assign rk   = 4'(cmd.r * 3 + cmd.k);
    assign kc   = 4'(cmd.k * 3 + cmd.c);
    assign rc   = 4'(cmd.r * 3 + cmd.c);
    assign ck   = 4'(cmd.c * 3 + cmd.k);

    always_comb begin
        case (cmd.phase)
            PH_QUAT: begin
                op_a = quat_reg[pair[3:2]];
                op_b = quat_reg[pair[1:0]];
            end
            PH_WMAT: begin
                op_a = amat_reg[rk];
                op_b = rot_reg[ck];
            end
            default: begin
                op_a = rot_reg[rk];
                op_b = imat_reg[kc];
            end
        endcase
    end

    // round half up: Q.30 terms drop 29 bits (factor of two), products drop 30
    always_comb begin
        if (cmd.phase == PH_QUAT) begin
            rsum = {prod_reg[63], prod_reg} + (65'sd1 <<< (QUAT_FRAC - 2));
            term = rsum[63:QUAT_FRAC-1];
        end else begin
            rsum = {prod_reg[63], prod_reg} + (65'sd1 <<< (QUAT_FRAC - 1));
            term = rsum[64:QUAT_FRAC];
        end
        acc_next = ((cmd.k == 2'd0) ? '0 : acc_reg) + ACC_W'(term);
        acc_sat  = sat32(acc_next);
    end

    always_comb begin
        one = ACC_W'(1) <<< QUAT_FRAC;
        xx = ACC_W'(term_reg[0]); yy = ACC_W'(term_reg[1]); zz = ACC_W'(term_reg[2]);
        xy = ACC_W'(term_reg[3]); xz = ACC_W'(term_reg[4]); yz = ACC_W'(term_reg[5]);
        xw = ACC_W'(term_reg[6]); yw = ACC_W'(term_reg[7]); zw = ACC_W'(term_reg[8]);
        rot_raw[0] = one - (yy + zz);
        rot_raw[1] = xy - zw;
        rot_raw[2] = xz + yw;
        rot_raw[3] = xy + zw;
        rot_raw[4] = one - (xx + zz);
        rot_raw[5] = yz - xw;
        rot_raw[6] = xz - yw;
        rot_raw[7] = yz + xw;
        rot_raw[8] = one - (xx + yy);
        for (int i = 0; i < 9; i++) begin
            rot_sat[i] = sat32(rot_raw[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            quat_reg[0] <= s_data.quat_x;
            quat_reg[1] <= s_data.quat_y;
            quat_reg[2] <= s_data.quat_z;
            quat_reg[3] <= s_data.quat_w;
            imat_reg[4'(s_data.row_index * 3)]     <= s_data.body_row_x;
            imat_reg[4'(s_data.row_index * 3 + 1)] <= s_data.body_row_y;
            imat_reg[4'(s_data.row_index * 3 + 2)] <= s_data.body_row_z;
        end
        if (cmd.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.acc_en) begin
            case (cmd.phase)
                PH_QUAT: term_reg[cmd.qidx] <= term;
                PH_AMAT: begin
                    acc_reg <= acc_next;
                    if (cmd.k == ROW_LAST) begin
                        amat_reg[rc] <= acc_sat[31:0];
                        if (acc_sat[32]) ov_reg[cmd.r] <= 1'b1;
                    end
                end
                PH_WMAT: begin
                    acc_reg <= acc_next;
                    if (cmd.k == ROW_LAST) begin
                        wmat_reg[rc] <= acc_sat[31:0];
                        if (acc_sat[32]) ov_reg[cmd.r] <= 1'b1;
                    end
                end
                default: acc_reg <= acc_next;
            endcase
        end
        if (cmd.rot_en) begin
            // a rotation overflow marks every row
            ov_reg <= {3{rot_sat[0][32] | rot_sat[1][32] | rot_sat[2][32] |
                         rot_sat[3][32] | rot_sat[4][32] | rot_sat[5][32] |
                         rot_sat[6][32] | rot_sat[7][32] | rot_sat[8][32]}};
            for (int i = 0; i < 9; i++) begin
                rot_reg[i] <= rot_sat[i][31:0];
            end
        end
    end

    assign obase = 4'(cmd.orow * 3);

    always_comb begin
        m_data.out_row  = cmd.orow;
        m_data.world_x  = wmat_reg[obase];
        m_data.world_y  = wmat_reg[obase + 4'd1];
        m_data.world_z  = wmat_reg[obase + 4'd2];
        m_data.overflow = ov_reg[cmd.orow];
        m_data.last_row = (cmd.orow == ROW_LAST);
    end

endmodule

>>> hdl/inertia_world_frame_rotation_core.sv
// ----------------------------------------------------------------------------
// inertia_world_frame_rotation_core
// rotates a body-frame inverse inertia matrix to world frame as R*I*R^T
// ----------------------------------------------------------------------------
//  channel  ports              direction  carries
//  s_       s_valid/s_ready    in         one body row plus orientation quaternion
//  m_       m_valid/m_ready    out        one world row with overflow and last flags
//
//  rows 0 and 1 are only stored; row 2 starts 9 rotation terms and
//  54 matrix products, each a multiply then an accumulate step on the single
//  shared 32x32 multiplier, plus one rotation update, then three output rows
//  input is held off from row 2 until the last world row is taken
//  a stalled m_ready holds the current row; aresetn (sync) clears control only
//  row index three is accepted and dropped
// ----------------------------------------------------------------------------
module inertia_world_frame_rotation_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iwfr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output iwfr_pkg::out_item_t m_data
);
    import iwfr_pkg::*;

    dp_cmd_t cmd;

    // sequencer owns all handshake timing
    iwfr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_row_index (s_data.row_index),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    // storage and arithmetic
    iwfr_datapath u_dp (
        .aclk   (aclk),
        .cmd    (cmd),
        .s_data (s_data),
        .m_data (m_data)
    );

    // never take a request while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while results pending");

    // row 2 request starts computation
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.row_index == ROW_LAST) |=> !s_ready)
        else $error("row 2 did not start computation");

    // last row ends the burst
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_row) |=> (!m_valid && s_ready))
        else $error("output did not end after last row");

    // a stalled result row keeps its index
    a_hold_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data.out_row)))
        else $error("stalled row changed");

endmodule

>>> tb/inertia_world_frame_rotation_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertia_world_frame_rotation_core_tb
// streams body-frame inverse inertia rows with orientation quaternions into
// the core, predicts R*I*R^T with saturation in fixed point, and checks every
// world row, its overflow flag and its last flag against that prediction
// ----------------------------------------------------------------------------
module inertia_world_frame_rotation_core_tb;
    import iwfr_pkg::*;

    localparam int  LONG_STALL = 400;
    localparam real HALF_CLK   = 10.0;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // predictor state: body rows and quaternion as loaded so far
    logic signed [31:0] body_rows [3][3];
    logic signed [31:0] held_quat [4];

    out_item_t world_rows_due [$];
    int        err_count     = 0;
    int        rows_checked  = 0;
    int        rows_sent     = 0;
    int        ovf_rows_seen = 0;
    bit        hold_results  = 1'b0;

    inertia_world_frame_rotation_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(HALF_CLK) aclk = ~aclk;

    // round half up then arithmetic shift right
    function automatic logic signed [127:0] round_shift(input logic signed [127:0] v,
                                                       input int s);
        logic signed [127:0] t;
        t = v + (128'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout bit ov);
        if (v > 128'sh7fffffff) begin
            ov = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sh80000000) begin
            ov = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // world-frame inverse inertia from the held rows and quaternion
    task automatic predict_world_rows();
        logic signed [127:0] qx, qy, qz, qw, one, acc;
        logic signed [127:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
        logic signed [127:0] rraw [3][3];
        logic signed [31:0]  rot [3][3];
        logic signed [31:0]  amat [3];
        out_item_t           res;
        bit                  rot_ov, ov;
        rot_ov = 1'b0;
        qx = held_quat[0]; qy = held_quat[1]; qz = held_quat[2]; qw = held_quat[3];
        one = 128'sd1 <<< QUAT_FRAC;
        xx = round_shift(qx * qx, 29); yy = round_shift(qy * qy, 29);
        zz = round_shift(qz * qz, 29); xy = round_shift(qx * qy, 29);
        xz = round_shift(qx * qz, 29); yz = round_shift(qy * qz, 29);
        xw = round_shift(qx * qw, 29); yw = round_shift(qy * qw, 29);
        zw = round_shift(qz * qw, 29);
        rraw[0][0] = one - (yy + zz); rraw[0][1] = xy - zw; rraw[0][2] = xz + yw;
        rraw[1][0] = xy + zw; rraw[1][1] = one - (xx + zz); rraw[1][2] = yz - xw;
        rraw[2][0] = xz - yw; rraw[2][1] = yz + xw; rraw[2][2] = one - (xx + yy);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                rot[r][c] = clamp32(rraw[r][c], rot_ov);
        for (int r = 0; r < 3; r++) begin
            ov = rot_ov;
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += round_shift(128'(rot[r][k]) * 128'(body_rows[k][c]), 30);
                amat[c] = clamp32(acc, ov);
            end
            res = '0;
            res.out_row = 2'(r);
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += round_shift(128'(amat[k]) * 128'(rot[c][k]), 30);
                case (c)
                    0: res.world_x = clamp32(acc, ov);
                    1: res.world_y = clamp32(acc, ov);
                    default: res.world_z = clamp32(acc, ov);
                endcase
            end
            res.overflow = ov;
            res.last_row = (2'(r) == ROW_LAST);
            world_rows_due = {world_rows_due, res};
        end
    endtask

    // send one request; valid held until accepted, then predicted
    // valid stays up after the accept so a zero gap runs back to back
    task automatic send_row(input in_item_t item, input bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        rows_sent++;
        if (item.row_index != ROW_NONE) begin
            held_quat[0] = item.quat_x; held_quat[1] = item.quat_y;
            held_quat[2] = item.quat_z; held_quat[3] = item.quat_w;
            body_rows[item.row_index][0] = item.body_row_x;
            body_rows[item.row_index][1] = item.body_row_y;
            body_rows[item.row_index][2] = item.body_row_z;
            if (item.row_index == ROW_LAST) predict_world_rows();
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 262143)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    // roughly unit quaternion with random sign pattern
    task automatic unit_quat(output in_item_t item);
        int a, b, cc;
        a  = $urandom_range(0, 1 << 29);
        b  = $urandom_range(0, 1 << 29);
        cc = $urandom_range(0, 1 << 29);
        item.quat_x = $urandom_range(0, 1) ? a : -a;
        item.quat_y = $urandom_range(0, 1) ? b : -b;
        item.quat_z = $urandom_range(0, 1) ? cc : -cc;
        item.quat_w = $urandom_range(0, 1) ? 32'sh30000000 : -32'sh30000000;
    endtask

    function automatic in_item_t make_row(input logic [1:0] idx, input logic [31:0] qx,
                                          input logic [31:0] qy, input logic [31:0] qz,
                                          input logic [31:0] qw, input logic [31:0] bx,
                                          input logic [31:0] by, input logic [31:0] bz);
        in_item_t it;
        it.row_index = idx;
        it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
        it.body_row_x = bx; it.body_row_y = by; it.body_row_z = bz;
        return it;
    endfunction

    // result channel: random backpressure, checks each world row in order
    always @(posedge aclk) begin
        out_item_t due;
        if (aresetn && m_valid && m_ready) begin
            if (world_rows_due.size() == 0) begin
                $display("%0t: unexpected world row, expected none, actual %p",
                         $realtime, m_data);
                err_count++;
            end else begin
                due = world_rows_due.pop_front();
                rows_checked++;
                if (m_data.overflow) ovf_rows_seen++;
                if (m_data !== due) begin
                    $display("%0t: world row mismatch, expected %p, actual %p",
                             $realtime, due, m_data);
                    err_count++;
                end
            end
        end
    end

    initial begin : receiver
        int wait_cycles;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge aclk);
                hold_results = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (wait_cycles - 1) @(negedge aclk);
                @(negedge aclk);
                m_ready <= 1'b1;
            end
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic drain_results();
        s_valid <= 1'b0;
        while (world_rows_due.size() != 0) @(posedge aclk);
        repeat (140) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_body(input in_item_t q, input bit gaps = 1'b1);
        for (int r = 0; r < 3; r++)
            send_row(make_row(2'(r), q.quat_x, q.quat_y, q.quat_z, q.quat_w,
                              rand_word(), rand_word(), rand_word()), gaps);
    endtask

    // identity and extreme quaternions, extreme matrix entries
    task automatic test_directed_extremes();
        in_item_t q;
        send_row(make_row(2'd0, 0, 0, 0, 32'h40000000, 32'h00010000, 0, 0));
        send_row(make_row(2'd1, 0, 0, 0, 32'h40000000, 0, 32'h00010000, 0));
        send_row(make_row(2'd2, 0, 0, 0, 32'h40000000, 0, 0, 32'h00010000));
        send_row(make_row(2'd0, 0, 0, 32'h2d413ccd, 32'h2d413ccd,
                          32'h7fffffff, 32'h80000000, 32'h7fffffff));
        send_row(make_row(2'd1, 0, 0, 32'h2d413ccd, 32'h2d413ccd,
                          32'h80000000, 32'h7fffffff, 32'h80000000));
        send_row(make_row(2'd2, 0, 0, 32'h2d413ccd, 32'h2d413ccd,
                          32'h7fffffff, 32'h80000000, 32'h7fffffff));
        // non-unit quaternions push the rotation matrix into saturation
        send_row(make_row(2'd2, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                          32'hffffffff, 32'hffffffff, 32'hffffffff));
        send_row(make_row(2'd2, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          0, 0, 0));
        send_row(make_row(2'd2, 32'hffffffff, 32'h00000001, 32'h55555555, 32'haaaaaaaa,
                          32'h55555555, 32'haaaaaaaa, 32'h00000001));
        // row index three is dropped without results
        send_row(make_row(ROW_NONE, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom));
        // rows out of order, reusing stored rows
        unit_quat(q);
        send_row(make_row(2'd1, q.quat_x, q.quat_y, q.quat_z, q.quat_w, 32'h00020000,
                          32'hfffe0000, 32'h00008000));
        send_row(make_row(2'd2, q.quat_x, q.quat_y, q.quat_z, q.quat_w, 32'h00001000,
                          32'h00003000, 32'hfff00000));
        send_row(make_row(2'd0, q.quat_x, q.quat_y, q.quat_z, q.quat_w, 0, 0, 0));
        send_row(make_row(2'd2, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom));
        drain_results();
    endtask

    // well-formed bodies with random content, plus stray and out-of-order rows
    task automatic test_random_stream(input int n_bodies);
        in_item_t q;
        for (int b = 0; b < n_bodies; b++) begin
            case ($urandom_range(0, 9))
                0: send_row(make_row(ROW_NONE, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom));
                1: send_row(make_row(2'($urandom_range(0, 2)), $urandom, $urandom,
                                     $urandom, $urandom, rand_word(), rand_word(),
                                     rand_word()));
                2: begin
                    q = '0;
                    q.quat_x = $urandom; q.quat_y = $urandom;
                    q.quat_z = $urandom; q.quat_w = $urandom;
                    send_body(q);
                end
                default: begin
                    unit_quat(q);
                    send_body(q);
                end
            endcase
        end
        drain_results();
    endtask

    // receiver stalls long while bodies keep coming back to back
    task automatic test_output_backpressure();
        in_item_t q;
        hold_results = 1'b1;
        for (int b = 0; b < 4; b++) begin
            unit_quat(q);
            send_body(q, 1'b0);
        end
        drain_results();
    endtask

    // sender waits for every result before each body
    task automatic test_paced_bodies();
        in_item_t q;
        for (int b = 0; b < 3; b++) begin
            unit_quat(q);
            send_body(q);
            s_valid <= 1'b0;
            while (world_rows_due.size() != 0) @(posedge aclk);
            @(negedge aclk);
        end
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_extremes();
        test_output_backpressure();
        test_random_stream(25);
        test_paced_bodies();
        $display("sent %0d requests, checked %0d world rows (%0d with overflow)",
                 rows_sent, rows_checked, ovf_rows_seen);
        $display("covered identity, extremes, dropped rows, reorder and long stalls");
        if (err_count == 0 && world_rows_due.size() == 0) begin
            $display("[inertia_world_frame_rotation_core] OK");
        end else begin
            $display("[inertia_world_frame_rotation_core] ERROR");
        end
        $finish;
    end

    initial begin
        #(20ms);
        $display("[inertia_world_frame_rotation_core] ERROR");
        $finish;
    end

endmodule
